>>> src/bbpa_pkg.sv
// Package for the bitmap block pool allocator.
// Holds the sizes, mark and status codes, and the command and status types shared by
// the controller, the datapath and the channel interfaces. Depends on nothing.
package bbpa_pkg;

  localparam int unsigned NUM_BLOCKS = 1024;
  localparam int unsigned IDX_W      = $clog2(NUM_BLOCKS);
  localparam int unsigned PTR_W      = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned BYTES_W    = 26;
  localparam int unsigned NEED_W     = BYTES_W + 1;
  localparam int unsigned LOG2_W     = 5;
  localparam int unsigned USED_W     = 11;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [LOG2_W-1:0] MAX_LOG2   = 5'd16;
  localparam logic [LOG2_W-1:0] RESET_LOG2 = 5'd6;
  localparam logic [USED_W-1:0] RESET_USED = 11'd1024;

  typedef enum logic [1:0] {
    MARK_FREE = 2'd0,
    MARK_LAST = 2'd1,
    MARK_OCC  = 2'd2
  } mark_e;

  typedef enum logic [2:0] {
    ST_ALLOC   = 3'd0,
    ST_NOSPACE = 3'd1,
    ST_FREED   = 3'd2,
    ST_IGNORED = 3'd3,
    ST_NOEND   = 3'd4
  } status_e;

  typedef enum logic {
    OPC_ALLOC = 1'b0,
    OPC_FREE  = 1'b1
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_LOG2  = 1'b0,
    CFG_BLOCKS_USED = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_PREP,
    OP_SCAN_INIT,
    OP_WALK_INIT,
    OP_SCAN,
    OP_MARK,
    OP_WALK
  } dp_op_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PREP,
    S_DECIDE,
    S_SCAN,
    S_MARK,
    S_WALK,
    S_RESP
  } ctl_state_e;

  typedef struct packed {
    dp_op_e  op;
    logic    out_load;
    status_e out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_free;
    logic zero_count;
    logic need_over;
    logic blk_over;
    logic found;
    logic scan_miss;
    logic walk_last;
    logic walk_end;
    logic mark_done;
    logic out_busy;
  } dp_status_t;

endpackage

>>> src/bbpa_req_if.sv
// Request channel interface of the bitmap block pool allocator.
// Carries valid, ready and one request beat. Depends on bbpa_pkg.
interface bbpa_req_if import bbpa_pkg::*; ();

  logic               valid;
  logic               ready;
  logic               opcode;
  logic [BYTES_W-1:0] byte_count;
  logic [BYTES_W-1:0] byte_offset;

  modport source (output valid, opcode, byte_count, byte_offset, input ready);
  modport sink (input valid, opcode, byte_count, byte_offset, output ready);

endinterface

>>> src/bbpa_rsp_if.sv
// Response channel interface of the bitmap block pool allocator.
// Carries valid, ready and one result beat. Depends on bbpa_pkg.
interface bbpa_rsp_if import bbpa_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [BYTES_W-1:0] run_offset;

  modport source (output valid, status, run_offset, input ready);
  modport sink (input valid, status, run_offset, output ready);

endinterface

>>> src/bbpa_cfg_if.sv
// Configuration write channel interface of the bitmap block pool allocator.
// Carries valid, ready, a register index and write data. Depends on bbpa_pkg.
interface bbpa_cfg_if import bbpa_pkg::*; ();

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);

endinterface

>>> src/bbpa_ctrl.sv
// Controller state machine of the bitmap block pool allocator.
// Sequences clearing, request decode, scan, mark, free walk and response.
// Depends on bbpa_pkg.
module bbpa_ctrl import bbpa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  dp_status_t status_i,
  output logic       in_ready_o,
  output dp_cmd_t    cmd_o
);

  ctl_state_e state_q, state_d;
  status_e    st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      st_q    <= ST_IGNORED;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    st_d       = st_q;
    in_ready_o = 1'b0;
    cmd_o      = '{op: OP_NONE, out_load: 1'b0, out_status: st_q};
    case (state_q)
      S_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (status_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.op = OP_PREP;
        state_d  = S_DECIDE;
      end
      S_DECIDE: begin
        if (status_i.is_free) begin
          if (status_i.zero_count || status_i.blk_over) begin
            st_d    = ST_IGNORED;
            state_d = S_RESP;
          end else begin
            cmd_o.op = OP_WALK_INIT;
            state_d  = S_WALK;
          end
        end else if (status_i.zero_count) begin
          st_d    = ST_IGNORED;
          state_d = S_RESP;
        end else if (status_i.need_over) begin
          st_d    = ST_NOSPACE;
          state_d = S_RESP;
        end else begin
          cmd_o.op = OP_SCAN_INIT;
          state_d  = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.op = OP_SCAN;
        if (status_i.found) begin
          state_d = S_MARK;
        end else if (status_i.scan_miss) begin
          st_d    = ST_NOSPACE;
          state_d = S_RESP;
        end
      end
      S_MARK: begin
        cmd_o.op = OP_MARK;
        if (status_i.mark_done) begin
          st_d    = ST_ALLOC;
          state_d = S_RESP;
        end
      end
      S_WALK: begin
        cmd_o.op = OP_WALK;
        if (status_i.walk_last) begin
          st_d    = ST_FREED;
          state_d = S_RESP;
        end else if (status_i.walk_end) begin
          st_d    = ST_NOEND;
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

>>> src/bbpa_dp.sv
// Datapath of the bitmap block pool allocator.
// Holds the configuration registers, the block mark memory, the scan and walk pointers
// and the response register. Driven by bbpa_ctrl commands; depends on bbpa_pkg.
module bbpa_dp import bbpa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  input  logic                  opcode_i,
  input  logic [BYTES_W-1:0]    byte_count_i,
  input  logic [BYTES_W-1:0]    byte_offset_i,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  cfg_ready_o,
  output logic                  rsp_valid_o,
  input  logic                  rsp_ready_i,
  output logic [2:0]            rsp_status_o,
  output logic [BYTES_W-1:0]    rsp_run_offset_o
);

  logic [LOG2_W-1:0]  lg_cfg_q;
  logic [USED_W-1:0]  used_cfg_q;
  logic               opc_q;
  logic [BYTES_W-1:0] count_q;
  logic [BYTES_W-1:0] offset_q;
  logic [NEED_W-1:0]  need_q;
  logic [BYTES_W-1:0] blk_q;
  logic [PTR_W-1:0]   ptr_q;
  logic               pend_q;
  logic [IDX_W-1:0]   pidx_q;
  logic [PTR_W-1:0]   run_q;
  logic [IDX_W-1:0]   start_q;
  logic [IDX_W-1:0]   end_q;
  logic [IDX_W-1:0]   wptr_q;
  logic [1:0]         marks_q [NUM_BLOCKS];
  logic [1:0]         rdata_q;
  logic               out_valid_q;
  logic [2:0]         out_status_q;
  logic [BYTES_W-1:0] out_offset_q;

  logic [LOG2_W-1:0]  lg_eff;
  logic [PTR_W-1:0]   used_eff;
  logic [NEED_W-1:0]  round_mask;
  logic               mark_free;
  logic               mark_last;
  logic               pidx_last;
  logic               ptr_in_range;
  logic [IDX_W-1:0]   start_sel;
  logic               found;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [1:0]         wdata;

  assign cfg_ready_o = 1'b1;

  assign lg_eff   = (lg_cfg_q > MAX_LOG2) ? MAX_LOG2 : lg_cfg_q;
  assign used_eff = (32'(used_cfg_q) > NUM_BLOCKS) ? PTR_W'(NUM_BLOCKS)
                                                     : PTR_W'(used_cfg_q);
  assign round_mask = ~({NEED_W{1'b1}} << lg_eff);

  assign mark_free    = (rdata_q == MARK_FREE);
  assign mark_last    = (rdata_q == MARK_LAST);
  assign pidx_last    = (PTR_W'(pidx_q) == (used_eff - PTR_W'(1)));
  assign ptr_in_range = (ptr_q < used_eff);
  assign start_sel    = (run_q == '0) ? pidx_q : start_q;
  assign found        = (cmd_i.op == OP_SCAN) && pend_q && mark_free &&
                        ((run_q + PTR_W'(1)) == need_q[PTR_W-1:0]);

  always_comb begin
    status_o            = '0;
    status_o.clr_done   = (cmd_i.op == OP_CLEAR) &&
                          (ptr_q[IDX_W-1:0] == IDX_W'(NUM_BLOCKS - 1));
    status_o.is_free    = (opc_q == OPC_FREE);
    status_o.zero_count = (count_q == '0);
    status_o.need_over  = (need_q > NEED_W'(used_eff));
    status_o.blk_over   = (blk_q >= BYTES_W'(used_eff));
    status_o.found      = found;
    status_o.scan_miss  = (cmd_i.op == OP_SCAN) && pend_q && !found && pidx_last;
    status_o.walk_last  = (cmd_i.op == OP_WALK) && pend_q && mark_last;
    status_o.walk_end   = (cmd_i.op == OP_WALK) && pend_q && pidx_last;
    status_o.mark_done  = (cmd_i.op == OP_MARK) && (wptr_q == end_q);
    status_o.out_busy   = out_valid_q && !rsp_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_cfg_q   <= RESET_LOG2;
      used_cfg_q <= RESET_USED;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_BLOCK_LOG2:  lg_cfg_q   <= cfg_data_i[LOG2_W-1:0];
        CFG_BLOCKS_USED: used_cfg_q <= cfg_data_i[USED_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      opc_q    <= opcode_i;
      count_q  <= byte_count_i;
      offset_q <= byte_offset_i;
    end
    if (cmd_i.op == OP_PREP) begin
      need_q <= ({1'b0, count_q} + round_mask) >> lg_eff;
      blk_q  <= offset_q >> lg_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      pend_q <= ((cmd_i.op == OP_SCAN) || (cmd_i.op == OP_WALK)) && ptr_in_range;
      case (cmd_i.op)
        OP_CLEAR:     ptr_q <= ptr_q + PTR_W'(1);
        OP_SCAN_INIT: ptr_q <= '0;
        OP_WALK_INIT: ptr_q <= PTR_W'(blk_q);
        OP_SCAN, OP_WALK: begin
          if (ptr_in_range) begin
            ptr_q <= ptr_q + PTR_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= ptr_q[IDX_W-1:0];
    if (cmd_i.op == OP_SCAN_INIT) begin
      run_q <= '0;
    end else if ((cmd_i.op == OP_SCAN) && pend_q) begin
      run_q   <= mark_free ? (run_q + PTR_W'(1)) : '0;
      start_q <= start_sel;
      if (found) begin
        wptr_q <= start_sel;
        end_q  <= pidx_q;
      end
    end else if (cmd_i.op == OP_MARK) begin
      wptr_q <= wptr_q + IDX_W'(1);
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = ptr_q[IDX_W-1:0];
    wdata = MARK_FREE;
    case (cmd_i.op)
      OP_CLEAR: begin
        we = 1'b1;
      end
      OP_MARK: begin
        we    = 1'b1;
        waddr = wptr_q;
        wdata = (wptr_q == end_q) ? MARK_LAST : MARK_OCC;
      end
      OP_WALK: begin
        we    = pend_q;
        waddr = pidx_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      marks_q[waddr] <= wdata;
    end
    rdata_q <= marks_q[ptr_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.out_status;
      out_offset_q <= (cmd_i.out_status == ST_ALLOC) ? (BYTES_W'(start_q) << lg_eff)
                                                     : '0;
    end
  end

  assign rsp_valid_o      = out_valid_q;
  assign rsp_status_o     = out_status_q;
  assign rsp_run_offset_o = out_offset_q;

  a_pend_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (PTR_W'(pidx_q) < used_eff))
    else $error("A pending mark read lies outside the blocks in use.");

  a_mark_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_MARK) |-> (wptr_q <= end_q))
    else $error("The mark write pointer has passed the end of the run.");

  a_found_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found |-> ((PTR_W'(pidx_q) - PTR_W'(start_sel) + PTR_W'(1)) == need_q[PTR_W-1:0]))
    else $error("A found run does not have the requested length.");

endmodule

>>> src/bitmap_block_pool_allocator.sv
// Bitmap first-fit block pool allocator: one request at a time, one response beat per
// request. After reset the mark memory is cleared, during which no request is taken
// (configuration writes still are). An allocate reads each block that it scans and then
// writes each block of its run, a free reads and clears each block that it walks, and a
// request answered without touching the marks does neither; all of these go through the
// single mark memory, which is read and written one mark per cycle.
// Depends on bbpa_pkg, the channel interfaces, bbpa_ctrl and bbpa_dp.
module bitmap_block_pool_allocator import bbpa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  bbpa_req_if.sink   req_i,
  bbpa_cfg_if.sink   cfg_i,
  bbpa_rsp_if.source rsp_o
);

  dp_cmd_t    cmd;
  dp_status_t dp_status;
  logic       in_ready;

  assign req_i.ready = in_ready;

  bbpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .status_i   (dp_status),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  bbpa_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (dp_status),
    .opcode_i         (req_i.opcode),
    .byte_count_i     (req_i.byte_count),
    .byte_offset_i    (req_i.byte_offset),
    .cfg_valid_i      (cfg_i.valid),
    .cfg_index_i      (cfg_i.index),
    .cfg_data_i       (cfg_i.data),
    .cfg_ready_o      (cfg_i.ready),
    .rsp_valid_o      (rsp_o.valid),
    .rsp_ready_i      (rsp_o.ready),
    .rsp_status_o     (rsp_o.status),
    .rsp_run_offset_o (rsp_o.run_offset)
  );

endmodule

>>> test/bitmap_block_pool_allocator_test.sv
// Self-checking testbench for the bitmap block pool allocator.
// Drives allocate and free requests through a directed table and then random phases, and
// checks every response beat against its typed table reply or a bit-accurate model of the
// block marks. Needs bbpa_pkg, the three channel interfaces and the allocator RTL.
module bitmap_block_pool_allocator_test import bbpa_pkg::*; ();

  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 2100;
  localparam int unsigned PHASES       = 9;
  localparam int unsigned PHASE_ITEMS  = 30;

  typedef enum {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct {
    status_e            status;
    logic [BYTES_W-1:0] run_offset;
  } reply_t;

  typedef struct {
    row_kind_e             kind;
    opcode_e               op;
    logic [BYTES_W-1:0]    count;
    logic [BYTES_W-1:0]    offset;
    bit                    typed;
    reply_t                reply;
    cfg_idx_e              reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
  } stim_row_t;

  logic clk;
  logic rst_n;

  bbpa_req_if req_if ();
  bbpa_rsp_if rsp_if ();
  bbpa_cfg_if cfg_if ();

  bitmap_block_pool_allocator u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .cfg_i  (cfg_if),
    .rsp_o  (rsp_if)
  );

  mark_e              pool_marks [NUM_BLOCKS];
  logic [LOG2_W-1:0]  cur_log2;
  logic [USED_W-1:0]  cur_used;
  reply_t             pending_replies [$];
  int unsigned        live_runs [$];
  stim_row_t          stim_rows [$];
  bit                 typed_reply_on;
  reply_t             typed_reply;
  bit                 quiet_mode;
  int                 hold_requests;
  int                 mismatch_count;
  int                 req_beats;
  int                 cfg_beats;
  int                 status_seen [5];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int unsigned block_shift();
    return (cur_log2 > MAX_LOG2) ? int'(MAX_LOG2) : int'(cur_log2);
  endfunction

  function automatic int unsigned usable_blocks();
    return (cur_used > NUM_BLOCKS) ? NUM_BLOCKS : int'(cur_used);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_mode || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic reply_t predict_pool_reply(opcode_e op, logic [BYTES_W-1:0] cnt,
                                                logic [BYTES_W-1:0] off);
    reply_t            r;
    int unsigned       lg;
    int unsigned       used;
    int unsigned       blk;
    int unsigned       start;
    int unsigned       i;
    longint unsigned   need;
    longint unsigned   run;
    bit                last;
    r.status     = ST_IGNORED;
    r.run_offset = '0;
    lg    = block_shift();
    used  = usable_blocks();
    start = 0;
    run   = 0;
    if (op == OPC_ALLOC) begin
      if (cnt == 0) return r;
      need = (longint'(cnt) + (longint'(1) << lg) - 1) >> lg;
      r.status = ST_NOSPACE;
      if (need > used) return r;
      for (i = 0; i < used && run < need; i++) begin
        if (pool_marks[i] == MARK_FREE) begin
          if (run == 0) start = i;
          run++;
        end else begin
          run = 0;
        end
      end
      if (run != need) return r;
      for (i = start; i + 1 < start + need; i++) pool_marks[i] = MARK_OCC;
      pool_marks[start + need - 1] = MARK_LAST;
      r.status     = ST_ALLOC;
      r.run_offset = BYTES_W'(start << lg);
    end else begin
      blk = off >> lg;
      if (cnt == 0 || blk >= used) return r;
      r.status = ST_NOEND;
      for (i = blk; i < used; i++) begin
        last = (pool_marks[i] == MARK_LAST);
        pool_marks[i] = MARK_FREE;
        if (last) begin
          r.status = ST_FREED;
          break;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    reply_t want;
    reply_t model;
    if (rsp_if.valid && rsp_if.ready) begin
      if (rsp_if.status <= 3'd4) status_seen[rsp_if.status]++;
      if (pending_replies.size() == 0) begin
        $error("response beat with nothing expected: status %0d run_offset %0d",
               rsp_if.status, rsp_if.run_offset);
        mismatch_count++;
      end else begin
        want = pending_replies.pop_front();
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
          mismatch_count++;
        end
        if (rsp_if.run_offset !== want.run_offset) begin
          $error("run_offset: expected %0d, actual %0d", want.run_offset, rsp_if.run_offset);
          mismatch_count++;
        end
      end
    end
    if (req_if.valid && req_if.ready) begin
      req_beats++;
      model = predict_pool_reply(opcode_e'(req_if.opcode), req_if.byte_count,
                                 req_if.byte_offset);
      if (model.status == ST_ALLOC) live_runs.push_back(model.run_offset >> block_shift());
      pending_replies.push_back(typed_reply_on ? typed_reply : model);
    end
    if (cfg_if.valid && cfg_if.ready) begin
      cfg_beats++;
      if (cfg_if.index == CFG_BLOCK_LOG2) cur_log2 = cfg_if.data[LOG2_W-1:0];
      else cur_used = cfg_if.data[USED_W-1:0];
    end
  end

  initial begin : response_sink
    int idle_left;
    int holds_served;
    idle_left    = 0;
    holds_served = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        idle_left = HOLD_CYCLES;
      end
      if (idle_left > 0) begin
        rsp_if.ready = 1'b0;
        idle_left--;
      end else begin
        rsp_if.ready = 1'b1;
        if ($urandom_range(0, 2) == 0) idle_left = pick_gap();
      end
    end
  end

  task automatic send_request(opcode_e op, logic [BYTES_W-1:0] cnt, logic [BYTES_W-1:0] off,
                              bit typed, reply_t typed_val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid       = 1'b1;
    req_if.opcode      = op;
    req_if.byte_count  = cnt;
    req_if.byte_offset = off;
    typed_reply_on     = typed;
    typed_reply        = typed_val;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
    @(negedge clk);
  endtask

  task automatic drain_replies();
    req_if.valid = 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic void add_req(opcode_e op, logic [BYTES_W-1:0] cnt,
                                  logic [BYTES_W-1:0] off);
    stim_row_t row;
    row.kind             = ROW_REQ;
    row.op               = op;
    row.count            = cnt;
    row.offset           = off;
    row.typed            = 1'b0;
    row.reply.status     = ST_ALLOC;
    row.reply.run_offset = '0;
    row.reg_idx          = CFG_BLOCK_LOG2;
    row.reg_data         = '0;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_typed(opcode_e op, logic [BYTES_W-1:0] cnt,
                                    logic [BYTES_W-1:0] off, status_e st,
                                    logic [BYTES_W-1:0] ro);
    stim_row_t row;
    row.kind             = ROW_REQ;
    row.op               = op;
    row.count            = cnt;
    row.offset           = off;
    row.typed            = 1'b1;
    row.reply.status     = st;
    row.reply.run_offset = ro;
    row.reg_idx          = CFG_BLOCK_LOG2;
    row.reg_data         = '0;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_cfg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row.kind             = ROW_CFG;
    row.op               = OPC_ALLOC;
    row.count            = '0;
    row.offset           = '0;
    row.typed            = 1'b0;
    row.reply.status     = ST_ALLOC;
    row.reply.run_offset = '0;
    row.reg_idx          = idx;
    row.reg_data         = data;
    stim_rows.push_back(row);
  endfunction

  task automatic random_request();
    int unsigned        r;
    int unsigned        lg;
    int unsigned        k;
    int unsigned        blk;
    opcode_e            op;
    logic [BYTES_W-1:0] cnt;
    logic [BYTES_W-1:0] off;
    reply_t             none;
    none = '{ST_ALLOC, '0};
    lg = block_shift();
    r  = $urandom_range(0, 99);
    if (r < 45 || (r < 80 && live_runs.size() == 0)) begin
      op  = OPC_ALLOC;
      cnt = ($urandom_range(0, 9) == 0) ? BYTES_W'($urandom_range(1, 64 << lg))
                                         : BYTES_W'($urandom_range(1, $urandom_range(1, 4) << lg));
      off = BYTES_W'($urandom);
    end else if (r < 80) begin
      k   = $urandom_range(0, live_runs.size() - 1);
      blk = live_runs[k];
      live_runs.delete(k);
      op  = OPC_FREE;
      cnt = BYTES_W'($urandom_range(1, 26'h3FF_FFFF));
      off = BYTES_W'((blk << lg) | ($urandom & ((32'd1 << lg) - 1)));
    end else begin
      op  = opcode_e'($urandom_range(0, 1));
      cnt = ($urandom_range(0, 3) == 0) ? '0 : BYTES_W'($urandom);
      if ($urandom_range(0, 1) == 0) off = BYTES_W'($urandom);
      else off = BYTES_W'(($urandom_range(0, usable_blocks() + 2) << lg)
                          | ($urandom & ((32'd1 << lg) - 1)));
    end
    send_request(op, cnt, off, 1'b0, none);
  endtask

  initial begin : stimulus
    int unsigned           used;
    int unsigned           lg;
    logic [CFG_DATA_W-1:0] lg_data;
    req_if.valid       = 1'b0;
    req_if.opcode      = OPC_ALLOC;
    req_if.byte_count  = '0;
    req_if.byte_offset = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = CFG_BLOCK_LOG2;
    cfg_if.data        = '0;
    typed_reply_on     = 1'b0;
    typed_reply        = '{ST_ALLOC, '0};
    quiet_mode         = 1'b0;
    hold_requests      = 0;
    mismatch_count     = 0;
    req_beats          = 0;
    cfg_beats          = 0;
    foreach (status_seen[s]) status_seen[s] = 0;
    foreach (pool_marks[b]) pool_marks[b] = MARK_FREE;
    cur_log2 = RESET_LOG2;
    cur_used = RESET_USED;
    rst_n    = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings first: 64-byte blocks, the whole pool in use.
    add_typed(OPC_ALLOC, '0, '0, ST_IGNORED, '0);
    add_typed(OPC_FREE, '0, '0, ST_IGNORED, '0);
    add_typed(OPC_FREE, 26'd1, '0, ST_NOEND, '0);
    add_typed(OPC_ALLOC, 26'd1, '0, ST_ALLOC, 26'd0);
    add_typed(OPC_ALLOC, 26'd64, '0, ST_ALLOC, 26'd64);
    add_typed(OPC_ALLOC, 26'd65, '0, ST_ALLOC, 26'd128);
    add_typed(OPC_ALLOC, 26'h3FF_FFFF, '0, ST_NOSPACE, '0);
    add_req(OPC_ALLOC, 26'd65536, '0);
    add_typed(OPC_FREE, 26'd1, 26'd64, ST_FREED, '0);
    add_req(OPC_FREE, 26'h3FF_FFFF, 26'd130);
    add_typed(OPC_FREE, 26'd1, 26'h3FF_FFFF, ST_IGNORED, '0);
    add_typed(OPC_FREE, 26'd1, 26'd65536, ST_IGNORED, '0);
    add_req(OPC_FREE, 26'd1, 26'd65535);
    add_req(OPC_ALLOC, 26'd192, '0);
    add_req(OPC_FREE, 26'd1, 26'd128);
    add_cfg(CFG_BLOCK_LOG2, 11'd0);
    add_cfg(CFG_BLOCKS_USED, 11'd0);
    add_typed(OPC_ALLOC, 26'd1, '0, ST_NOSPACE, '0);
    add_typed(OPC_FREE, 26'd1, '0, ST_IGNORED, '0);
    add_cfg(CFG_BLOCKS_USED, 11'd2047);
    add_cfg(CFG_BLOCK_LOG2, 11'd31);
    add_req(OPC_ALLOC, 26'h3FF_FFFF, '0);
    add_req(OPC_FREE, 26'd1, '0);
    add_req(OPC_ALLOC, 26'd65536, '0);
    add_cfg(CFG_BLOCK_LOG2, 11'h7F1);
    add_cfg(CFG_BLOCKS_USED, 11'd1);
    add_req(OPC_ALLOC, 26'd1, '0);
    add_req(OPC_ALLOC, 26'd2, '0);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        drain_replies();
        write_register(stim_rows[i].reg_idx, stim_rows[i].reg_data);
      end else begin
        send_request(stim_rows[i].op, stim_rows[i].count, stim_rows[i].offset,
                     stim_rows[i].typed, stim_rows[i].reply);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain_replies();
      case (p)
        2:       used = 1024;
        4:       used = 1;
        6:       used = 2047;
        default: used = $urandom_range(2, 48);
      endcase
      case (p)
        0:       lg = 6;
        3:       lg = 0;
        5:       lg = 16;
        7:       lg = $urandom_range(17, 31);
        default: lg = $urandom_range(0, 12);
      endcase
      lg_data = (p == 8) ? {6'($urandom), 5'(lg)} : CFG_DATA_W'(lg);
      write_register(CFG_BLOCKS_USED, CFG_DATA_W'(used));
      write_register(CFG_BLOCK_LOG2, lg_data);
      // The long response stall fills the block while requests keep coming.
      if (p == 1) hold_requests <= hold_requests + 1;
      quiet_mode <= (p == 4);
      repeat (PHASE_ITEMS) random_request();
    end

    drain_replies();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_replies.size() != 0) begin
      $error("%0d expected responses never arrived", pending_replies.size());
      mismatch_count++;
    end
    $display("Run covered %0d requests and %0d register writes over %0d random phases.",
             req_beats, cfg_beats, PHASES);
    $display("Results: %0d allocated, %0d no space, %0d freed, %0d ignored, %0d no run end.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
